// ===== hdl/fixed_partition_allocator_assert.svh =====
// Assertion macros for the fixed-partition allocator.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef FIXED_PARTITION_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define FPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fixed_partition_allocator: assertion failed");
// Condition that must never be true outside reset.
`define FPA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("fixed_partition_allocator: forbidden condition seen");
`else
`define FPA_ASSERT(lbl, prop)
`define FPA_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== hdl/fpa_pkg.sv =====
// Shared types, codes and constants of the fixed-partition allocator.
// No dependencies.
package fpa_pkg;

  // Default sizing of the partition table.
  localparam int MAX_PARTITIONS_DEF = 16;
  localparam int SIZE_WIDTH_DEF     = 16;

  // Fixed field widths.
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 4;
  localparam int FSIZE_W  = 16;
  localparam int PID_W    = 16;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'b1;
  localparam logic [COUNT_W-1:0]   PART_COUNT_RST = 5'd16;

  // Item actions.
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REQ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  // Placement policies.
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } fpa_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic finish;
  } fpa_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_req;
    logic scan_done;
    logic out_free;
  } fpa_stat_t;

endpackage

// ===== hdl/fpa_ctrl.sv =====
// Controller state machine of the fixed-partition allocator.
// Depends on fpa_pkg; drives commands to fpa_datapath.
module fpa_ctrl
  import fpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fpa_stat_t stat_i,
  output fpa_cmd_t  cmd_o
);

  fpa_state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.is_req ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Only an idle controller takes a new item.
  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/fpa_datapath.sv =====
// Datapath of the fixed-partition allocator: tables, scan unit, output register.
// Depends on fpa_pkg; driven by fpa_ctrl commands.
module fpa_datapath
  import fpa_pkg::*;
#(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
  parameter int SIZE_WIDTH     = SIZE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fpa_cmd_t              cmd_i,
  output fpa_stat_t             stat_o,
  // Configuration write.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input item.
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [INDEX_W-1:0]    partition_index_i,
  input  logic [FSIZE_W-1:0]    size_i,
  input  logic [PID_W-1:0]      process_id_i,
  // Result item.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [INDEX_W-1:0]    chosen_index_o,
  output logic                  allocated_o,
  output logic [PID_W-1:0]      owner_id_o
);

  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CAP   = (MAX_PARTITIONS > 31) ? 31 : MAX_PARTITIONS;

  // Configuration registers.
  logic [MODE_W-1:0]  fit_mode_q;
  logic [COUNT_W-1:0] part_count_q;
  logic [COUNT_W-1:0] count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q   <= MODE_BEST;
      part_count_q <= PART_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FIT_MODE:   fit_mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_PART_COUNT: part_count_q <= cfg_data_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Counts above the table capacity act as the capacity.
  assign count = (part_count_q > COUNT_W'(CAP)) ? COUNT_W'(CAP) : part_count_q;

  // Captured item.
  logic [ACTION_W-1:0]   action_q;
  logic [INDEX_W-1:0]    idx_q;
  logic [SIZE_WIDTH-1:0] req_q;
  logic [PID_W-1:0]      pid_q;
  logic                  in_range;
  logic [IDX_W-1:0]      item_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      idx_q    <= partition_index_i;
      req_q    <= SIZE_WIDTH'(size_i);
      pid_q    <= process_id_i;
    end
  end

  assign in_range  = ({1'b0, idx_q} < count);
  assign item_addr = IDX_W'(idx_q);

  // Partition tables: sizes and owners in memories, busy flags in flops.
  logic [SIZE_WIDTH-1:0]     size_mem  [MAX_PARTITIONS];
  logic [PID_W-1:0]          owner_mem [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] busy_q;
  logic [PID_W-1:0]          owner_rd_q;

  // Scan unit state.
  logic [COUNT_W-1:0]    ptr_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [SIZE_WIDTH-1:0] rd_size_q;
  logic                  found_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [SIZE_WIDTH-1:0] best_size_q;
  logic                  issue;
  logic                  hit;
  logic                  take;
  logic                  commit;

  assign issue  = cmd_i.scan && (ptr_q < count);
  assign commit = cmd_i.finish && (action_q == ACT_REQ) && found_q;

  // A free partition large enough either starts or improves the pick.
  assign hit  = rd_vld_q && !busy_q[rd_idx_q] && (rd_size_q >= req_q);
  assign take = hit && (!found_q
             || ((fit_mode_q == MODE_BEST)  && (rd_size_q < best_size_q))
             || ((fit_mode_q == MODE_WORST) && (rd_size_q > best_size_q)));

  // Size memory: written by loads, read once per scan step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (action_q == ACT_LOAD) && in_range) begin
      size_mem[item_addr] <= SIZE_WIDTH'(req_q);
    end
    if (issue) begin
      rd_size_q <= size_mem[IDX_W'(ptr_q)];
      rd_idx_q  <= IDX_W'(ptr_q);
    end
  end

  // Owner memory: written at allocation, read for queries.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      owner_mem[best_idx_q] <= pid_q;
    end
    if (cmd_i.exec) begin
      owner_rd_q <= owner_mem[item_addr];
    end
  end

  // Busy flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      if (cmd_i.exec && (action_q == ACT_LOAD) && in_range) begin
        busy_q[item_addr] <= 1'b0;
      end
      if (commit) begin
        busy_q[best_idx_q] <= 1'b1;
      end
    end
  end

  // Scan pointer, read pipeline and running pick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (issue) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q  <= rd_idx_q;
      best_size_q <= rd_size_q;
    end
  end

  // Result of the current item.
  logic [STATUS_W-1:0] res_status;
  logic [INDEX_W-1:0]  res_index;
  logic                res_alloc;
  logic [PID_W-1:0]    res_owner;

  always_comb begin
    res_status = STAT_OK;
    res_index  = idx_q;
    res_alloc  = 1'b0;
    res_owner  = '0;
    case (action_q)
      ACT_LOAD: begin
        if (!in_range) begin
          res_status = STAT_RANGE;
        end
      end
      ACT_REQ: begin
        if (found_q) begin
          res_index = INDEX_W'(best_idx_q);
        end else begin
          res_status = STAT_NOFIT;
          res_index  = '0;
        end
      end
      default: begin
        if (!in_range) begin
          res_status = STAT_RANGE;
        end else if (busy_q[item_addr]) begin
          res_alloc = 1'b1;
          res_owner = owner_rd_q;
        end
      end
    endcase
  end

  // Output register; holds while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o       <= res_status;
      chosen_index_o <= res_index;
      allocated_o    <= res_alloc;
      owner_id_o     <= res_owner;
    end
  end

  // Status to the controller.
  assign stat_o.is_req    = (action_q == ACT_REQ);
  assign stat_o.scan_done = !issue && !rd_vld_q;
  assign stat_o.out_free  = !out_valid_o || !out_stall_i;

endmodule

// ===== hdl/fixed_partition_allocator.sv =====
// Fixed-partition allocator with best, worst and first fit placement.
// Input and result channels use valid/stall; a configuration channel uses
// valid/ready and is always ready. Configuration registers: index 0 is the
// fit mode, index 1 the partition count.
// Each accepted item gives exactly one result. A load or a query passes from
// capture through the execute state to the done state, where its result is
// written to the output register. A request also passes through the scan
// state, which covers the N partitions in use (the count, capped at the
// table size): the scan reads one size memory entry per cycle through one
// comparator, and ends once no registered read is left in flight. The block
// takes one item at a time; the next input transfer can happen the cycle
// after the result is written to the output register, even while that
// result still waits for the receiver.
// A stalled result holds in the output register; while it is held, the
// next item runs up to its result and then waits.
// Reset clears the busy flags, the controller and the output valid, and
// sets fit mode to best fit and the partition count to 16. Partition sizes
// and owners are not cleared; a partition must be loaded before use.
// Depends on fpa_pkg, fpa_ctrl, fpa_datapath and the assertion macro header.
`include "fixed_partition_allocator_assert.svh"
module fixed_partition_allocator
  import fpa_pkg::*;
#(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
  parameter int SIZE_WIDTH     = SIZE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [INDEX_W-1:0]    partition_index_i,
  input  logic [FSIZE_W-1:0]    size_i,
  input  logic [PID_W-1:0]      process_id_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [INDEX_W-1:0]    chosen_index_o,
  output logic                  allocated_o,
  output logic [PID_W-1:0]      owner_id_o
);

  fpa_cmd_t  cmd;
  fpa_stat_t stat;

  // Configuration writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  fpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fpa_datapath #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_WIDTH     (SIZE_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .action_i          (action_i),
    .partition_index_i (partition_index_i),
    .size_i            (size_i),
    .process_id_i      (process_id_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .chosen_index_o    (chosen_index_o),
    .allocated_o       (allocated_o),
    .owner_id_o        (owner_id_o)
  );

  // An accepted item blocks the input until its result is written.
  `FPA_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // At most one controller command per cycle.
  `FPA_ASSERT(a_cmd_onehot0, $onehot0({cmd.capture, cmd.exec, cmd.scan, cmd.finish}))
  // A finished item always shows up as a valid result.
  `FPA_ASSERT(a_finish_gives_result, cmd.finish |=> out_valid_o)
  // A result is never written over one the receiver has not taken.
  `FPA_ASSERT_NEVER(a_no_overwrite, cmd.finish && out_valid_o && out_stall_i)

endmodule

// ===== bench/fpa_checker.sv =====
// Checker for the fixed-partition allocator: watches the configuration, input and
// result channels, keeps its own partition table and compares every result transfer.
// Depends on fpa_pkg for field widths, action, mode and status codes.
module fpa_checker
  import fpa_pkg::*;
#(
  parameter int MAX_PARTS = MAX_PARTITIONS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration channel.
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input channel.
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [INDEX_W-1:0]    partition_index_i,
  input  logic [FSIZE_W-1:0]    size_i,
  input  logic [PID_W-1:0]      process_id_i,
  // Result channel.
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [STATUS_W-1:0]   status_i,
  input  logic [INDEX_W-1:0]    chosen_index_i,
  input  logic                  allocated_i,
  input  logic [PID_W-1:0]      owner_id_i,
  // Summary toward the testbench top.
  output int                    fail_count_o,
  output int                    outstanding_o,
  output int                    checked_o
);

  // One result item as the block should return it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  chosen;
    logic                allocated;
    logic [PID_W-1:0]    owner;
  } alloc_reply_t;

  // Shadow copy of the partition table and the two registers.
  logic [FSIZE_W-1:0] size_tbl  [MAX_PARTS];
  bit                 busy_tbl  [MAX_PARTS];
  logic [PID_W-1:0]   owner_tbl [MAX_PARTS];
  logic [MODE_W-1:0]  fit_mode;
  logic [COUNT_W-1:0] part_count;

  // Replies owed by the block, oldest first.
  alloc_reply_t replies_due [$];
  int errors;
  int checked;

  // Apply one item to the shadow table and return the reply it must produce.
  function automatic alloc_reply_t serve_item(input logic [ACTION_W-1:0] act,
                                              input logic [INDEX_W-1:0]  idx,
                                              input logic [FSIZE_W-1:0]  sz,
                                              input logic [PID_W-1:0]    pid);
    alloc_reply_t r;
    int live;
    int pick;
    int j;
    bit found;
    r = '0;
    live = (part_count > MAX_PARTS) ? MAX_PARTS : int'(part_count);
    pick = 0;
    found = 1'b0;
    r.chosen = idx;
    if (act == ACT_LOAD) begin
      if (idx < live) begin
        size_tbl[idx] = sz;
        busy_tbl[idx] = 1'b0;
      end else begin
        r.status = STAT_RANGE;
      end
    end else if (act == ACT_REQ) begin
      // Scan the free partitions that are large enough; later candidates only
      // replace the pick when strictly better, so ties stay at the lowest index.
      for (j = 0; j < live; j++) begin
        if (!busy_tbl[j] && size_tbl[j] >= sz) begin
          if (!found) begin
            found = 1'b1;
            pick = j;
          end else if (fit_mode == MODE_BEST && size_tbl[j] < size_tbl[pick]) begin
            pick = j;
          end else if (fit_mode == MODE_WORST && size_tbl[j] > size_tbl[pick]) begin
            pick = j;
          end
        end
      end
      if (found) begin
        busy_tbl[pick] = 1'b1;
        owner_tbl[pick] = pid;
        r.chosen = pick[INDEX_W-1:0];
      end else begin
        r.status = STAT_NOFIT;
        r.chosen = '0;
      end
    end else begin
      // Queries, and the unused action code, report flag and owner.
      if (idx >= live) begin
        r.status = STAT_RANGE;
      end else if (busy_tbl[idx]) begin
        r.allocated = 1'b1;
        r.owner = owner_tbl[idx];
      end
    end
    return r;
  endfunction

  // Report one field that differs from the expected reply.
  task automatic compare_field(input string field, input logic [PID_W-1:0] want,
                               input logic [PID_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Track register writes, predict on input transfers, check result transfers.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    alloc_reply_t want;
    if (!rst_ni) begin
      foreach (busy_tbl[k]) busy_tbl[k] = 1'b0;
      fit_mode = MODE_BEST;
      part_count = PART_COUNT_RST;
      replies_due.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_FIT_MODE) begin
          fit_mode = cfg_data_i[MODE_W-1:0];
        end else begin
          part_count = cfg_data_i;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result transfer with none expected: status %0d, index %0d",
                   $time, status_i, chosen_index_i);
          errors++;
        end else begin
          want = replies_due.pop_front();
          compare_field("status", PID_W'(want.status), PID_W'(status_i));
          compare_field("chosen_index", PID_W'(want.chosen), PID_W'(chosen_index_i));
          compare_field("allocated", PID_W'(want.allocated), PID_W'(allocated_i));
          compare_field("owner_id", want.owner, owner_id_i);
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        replies_due.push_back(serve_item(action_i, partition_index_i, size_i,
                                         process_id_i));
      end
    end
    fail_count_o <= errors;
    outstanding_o <= replies_due.size();
    checked_o <= checked;
  end

endmodule

// ===== bench/testbench.sv =====
// Testbench top for the fixed-partition allocator: clock, reset, register writes,
// directed and random item streams with random idling, and the final verdict.
// Depends on fpa_pkg, fixed_partition_allocator and fpa_checker.
module testbench;
  import fpa_pkg::*;

  // Codes the package leaves unnamed; the block must treat them as query and first fit.
  localparam logic [ACTION_W-1:0] ACT_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0]   MODE_SPARE = 2'd3;

  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 47;
  localparam int HOLD_PHASE      = 2;
  localparam int LONG_HOLD       = 150;
  localparam int SETTLE_CYCLES   = 6;
  localparam int LIMIT_CYCLES    = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ACTION_W-1:0]   action = '0;
  logic [INDEX_W-1:0]    part_index = '0;
  logic [FSIZE_W-1:0]    size = '0;
  logic [PID_W-1:0]      pid = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [INDEX_W-1:0]    chosen_index;
  logic                  allocated;
  logic [PID_W-1:0]      owner_id;

  int fail_count;
  int outstanding;
  int checked;
  bit hold_off_req = 1'b0;
  bit quiet = 1'b0;
  int n_load = 0;
  int n_req = 0;
  int n_query = 0;
  int n_settings = 0;

  // Partition sizes loaded first: both extremes and repeated values for ties.
  logic [FSIZE_W-1:0] layout_sizes [16] = '{
    16'd0, 16'hFFFF, 16'd100, 16'd300, 16'd100, 16'd50, 16'd300, 16'd1000,
    16'd100, 16'd2000, 16'd40000, 16'd300, 16'd7, 16'd100, 16'd50000, 16'd12
  };
  logic [MODE_W-1:0] mode_cycle [4] = '{MODE_BEST, MODE_WORST, MODE_FIRST, MODE_SPARE};

  fixed_partition_allocator uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .action_i          (action),
    .partition_index_i (part_index),
    .size_i            (size),
    .process_id_i      (pid),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .chosen_index_o    (chosen_index),
    .allocated_o       (allocated),
    .owner_id_o        (owner_id)
  );

  fpa_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .action_i          (action),
    .partition_index_i (part_index),
    .size_i            (size),
    .process_id_i      (pid),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .status_i          (status),
    .chosen_index_i    (chosen_index),
    .allocated_i       (allocated),
    .owner_id_i        (owner_id),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding),
    .checked_o         (checked)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one item and hold it until the input transfer.
  task automatic offer(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                       input logic [FSIZE_W-1:0] sz, input logic [PID_W-1:0] id);
    in_valid <= 1'b1;
    action <= act;
    part_index <= idx;
    size <= sz;
    pid <= id;
    do @(posedge clk); while (in_stall);
    if (act == ACT_LOAD) begin
      n_load++;
    end else if (act == ACT_REQ) begin
      n_req++;
    end else begin
      n_query++;
    end
  endtask

  // Stop offering and wait until every expected result has been checked.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; the upper data bits of the mode write are noise.
  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[MODE_W-1:0] = mode;
    cfg_valid <= 1'b1;
    cfg_index <= REG_FIT_MODE;
    cfg_data <= word;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_PART_COUNT;
    cfg_data <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Sizes biased toward small values so requests often fit and tie.
  function automatic logic [FSIZE_W-1:0] pick_size();
    case ($urandom_range(0, 3))
      0: return FSIZE_W'($urandom_range(0, 255));
      1: return FSIZE_W'($urandom_range(0, 15));
      2: return ($urandom_range(0, 1) == 0) ? {FSIZE_W{1'b0}} : {FSIZE_W{1'b1}};
      default: return FSIZE_W'($urandom);
    endcase
  endfunction

  // Result receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    bit held_once;
    held_once = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_off_req && !held_once) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        held_once = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [ACTION_W-1:0] act;
    logic [COUNT_W-1:0]  count;
    int sel;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every partition first, so that no scan ever meets an unloaded size.
    for (int i = 0; i < 16; i++) begin
      offer(ACT_LOAD, INDEX_W'(i), layout_sizes[i], PID_W'($urandom));
    end
    // Best fit at reset settings: ties, largest and zero sizes, queries, no fit, reload.
    offer(ACT_REQ, 4'd0, 16'd100, 16'hFFFF);
    offer(ACT_REQ, 4'hF, 16'hFFFF, 16'h0000);
    offer(ACT_REQ, 4'd0, 16'd0, 16'h1234);
    offer(ACT_QUERY, 4'd2, 16'd0, 16'd0);
    offer(ACT_SPARE, 4'd1, 16'hFFFF, 16'hFFFF);
    offer(ACT_QUERY, 4'd3, 16'd0, 16'd0);
    offer(ACT_REQ, 4'd0, 16'hFFFF, 16'hA5A5);
    offer(ACT_LOAD, 4'd1, 16'hFFFF, 16'h5A5A);
    drain_results();

    // Worst fit with a count above capacity.
    set_config(MODE_WORST, 5'd31);
    offer(ACT_REQ, 4'd0, 16'd10, 16'h0101);
    offer(ACT_QUERY, 4'hF, 16'd0, 16'd0);
    offer(ACT_REQ, 4'd0, 16'd50, 16'h0202);
    drain_results();

    // Zero count: requests find nothing, loads and queries are out of range.
    set_config(MODE_FIRST, 5'd0);
    offer(ACT_REQ, 4'd0, 16'd0, 16'h0303);
    offer(ACT_LOAD, 4'd0, 16'd5, 16'h0404);
    offer(ACT_QUERY, 4'd5, 16'd0, 16'd0);
    drain_results();

    // Unused mode code with a small count.
    set_config(MODE_SPARE, 5'd5);
    offer(ACT_LOAD, 4'd7, 16'd9, 16'h0505);
    offer(ACT_REQ, 4'd0, 16'd20, 16'h0606);
    offer(ACT_QUERY, 4'd9, 16'd0, 16'd0);
    drain_results();

    // Random phases, each under its own register setting; the last one runs without idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1: count = 5'd1;
        3: count = 5'd31;
        5: count = 5'd0;
        7: count = 5'd16;
        default: count = ($urandom_range(0, 2) == 0) ? COUNT_W'($urandom_range(17, 31))
                                                     : COUNT_W'($urandom_range(2, 16));
      endcase
      set_config(mode_cycle[p % 4], count);
      quiet = (p == RANDOM_PHASES - 1);
      if (p == HOLD_PHASE) hold_off_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (!quiet && p != HOLD_PHASE && $urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          act = ACT_LOAD;
        end else if (sel < 70) begin
          act = ACT_REQ;
        end else if (sel < 95) begin
          act = ACT_QUERY;
        end else begin
          act = ACT_SPARE;
        end
        offer(act, INDEX_W'($urandom_range(0, 15)), pick_size(), PID_W'($urandom));
      end
      drain_results();
    end

    $display("Run covered %0d loads, %0d requests and %0d queries under %0d register settings,",
             n_load, n_req, n_query, n_settings);
    $display("including a long result hold-off; %0d results were compared.", checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("Run did not finish within %0d cycles.", LIMIT_CYCLES);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
